FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the gga field extractor
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// when trig holds, cond holds at the next clock edge
`define ASSERT_NEXT(name, clk, rst, trig, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("next-cycle check violated");

// when trig holds, cond holds in the same cycle
`define ASSERT_IMPLY(name, clk, rst, trig, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("implication violated");

`endif

FILE: rtl/ngfe_pkg.sv
// ----------------------------------------------------------------------------
// ngfe_pkg
// types, constants and tables shared by the gga field extractor
// ----------------------------------------------------------------------------
package ngfe_pkg;

   localparam int ID_CHARS_DEFAULT = 6;
   localparam int ID_CHARS_MAX     = 8;
   localparam int RSP_DEPTH        = 4;

   localparam logic [9:0]  MAX_LINE_RESET    = 10'd1000;
   localparam logic [47:0] SENTENCE_ID_RESET = 48'h2447_5047_4741; // "$GPGGA"

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_COMMA = 8'd44;

   localparam logic [3:0] CNT4_MAX   = 4'd15;
   localparam logic [2:0] FIELD_NONE = 3'd7;

   // register index decoded from the address
   localparam logic REG_MAX_LINE    = 1'b0;
   localparam logic REG_SENTENCE_ID = 1'b1;

   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_LINE_END  = 2'd1,
      KIND_TRUNCATED = 2'd2
   } result_kind_type;

   typedef struct packed {
      result_kind_type kind;
      logic [2:0]      field_id;
      logic [3:0]      char_index;
      logic [7:0]      char_value;
      logic            is_match;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

   typedef struct packed {
      logic [9:0]  max_line;
      logic [47:0] sentence_id;
   } cfg_type;

   // comma field number to output field id
   function automatic logic [2:0] field_of(input logic [3:0] field_number);
      logic [2:0] f;
      begin
         unique case (field_number)
            4'd1:    f = 3'd0;
            4'd2:    f = 3'd1;
            4'd3:    f = 3'd2;
            4'd4:    f = 3'd3;
            4'd5:    f = 3'd4;
            4'd7:    f = 3'd5;
            default: f = FIELD_NONE;
         endcase
         return f;
      end
   endfunction

   // characters kept per output field
   function automatic logic [3:0] cap_of(input logic [2:0] field_id);
      logic [3:0] c;
      begin
         unique case (field_id)
            3'd0:    c = 4'd10;
            3'd1:    c = 4'd9;
            3'd2:    c = 4'd1;
            3'd3:    c = 4'd10;
            3'd4:    c = 4'd1;
            3'd5:    c = 4'd2;
            default: c = 4'd0;
         endcase
         return c;
      end
   endfunction

endpackage

FILE: rtl/ngfe_csr.sv
// ----------------------------------------------------------------------------
// ngfe_csr
// apb register file holding line limit and sentence identifier
// ----------------------------------------------------------------------------
module ngfe_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready,
   output ngfe_pkg::cfg_type cfg
);

   logic [9:0]  max_line_ff;
   logic [9:0]  max_line_in;
   logic [47:0] sentence_id_ff;
   logic [47:0] sentence_id_in;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3];

   always_comb begin
      max_line_in    = max_line_ff;
      sentence_id_in = sentence_id_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ngfe_pkg::REG_MAX_LINE:    max_line_in    = pwdata[9:0];
            ngfe_pkg::REG_SENTENCE_ID: sentence_id_in = pwdata[47:0];
            default:                   max_line_in    = max_line_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff    <= ngfe_pkg::MAX_LINE_RESET;
         sentence_id_ff <= ngfe_pkg::SENTENCE_ID_RESET;
      end else begin
         max_line_ff    <= max_line_in;
         sentence_id_ff <= sentence_id_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         ngfe_pkg::REG_MAX_LINE:    prdata = {54'd0, max_line_ff};
         ngfe_pkg::REG_SENTENCE_ID: prdata = {16'd0, sentence_id_ff};
         default:                   prdata = 64'd0;
      endcase
   end

   assign cfg.max_line    = max_line_ff;
   assign cfg.sentence_id = sentence_id_ff;

endmodule

FILE: rtl/ngfe_parser.sv
// ----------------------------------------------------------------------------
// ngfe_parser
// line framing, identifier match and field capture for one byte per cycle while fire is set
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ngfe_parser #(
   parameter int ID_CHARS = ngfe_pkg::ID_CHARS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  ngfe_pkg::cfg_type  cfg,
   input  logic               fire,
   input  logic [7:0]         rx_byte,
   output ngfe_pkg::push_type push_a,
   output ngfe_pkg::push_type push_b
);

   localparam logic [3:0] ID_LEN = 4'(ID_CHARS);

   logic [9:0] stored_count_ff;
   logic [9:0] stored_count_in;
   logic [3:0] field_number_ff;
   logic [3:0] field_number_in;
   logic [3:0] pos_in_field_ff;
   logic [3:0] pos_in_field_in;
   logic       id_match_ff;
   logic       id_match_in;
   logic       cr_pending_ff;
   logic       cr_pending_in;

   logic [7:0] id_char [ngfe_pkg::ID_CHARS_MAX];
   logic [9:0] limit;
   logic [2:0] fid;
   logic       cur_match;
   logic       next_match;
   logic       line_reset;
   logic       lf_end;

   // identifier characters, first one in the highest used byte
   for (genvar k = 0; k < ngfe_pkg::ID_CHARS_MAX; k++) begin : g_id
      if (k < ID_CHARS && (ID_CHARS - 1 - k) * 8 < 48) begin : g_used
         assign id_char[k] = cfg.sentence_id[(ID_CHARS - 1 - k) * 8 +: 8];
      end else begin : g_zero
         assign id_char[k] = 8'd0;
      end
   end

   assign limit = (cfg.max_line >= 10'd3) ? (cfg.max_line - 10'd2) : 10'd1;
   assign fid   = ngfe_pkg::field_of(field_number_ff);

   assign cur_match = (field_number_ff == 4'd0) ?
                      (id_match_ff && pos_in_field_ff == ID_LEN) : id_match_ff;

   assign lf_end = fire && cr_pending_ff && rx_byte == ngfe_pkg::CHAR_LF;

   always_comb begin
      stored_count_in = stored_count_ff;
      field_number_in = field_number_ff;
      pos_in_field_in = pos_in_field_ff;
      id_match_in     = id_match_ff;
      cr_pending_in   = cr_pending_ff;
      line_reset      = 1'b0;
      next_match      = 1'b0;
      push_a          = '0;
      push_b          = '0;
      push_a.item.is_match = 1'b1;
      push_b.item.is_match = 1'b1;

      if (fire) begin
         priority if (cr_pending_ff) begin
            cr_pending_in = 1'b0;
            if (rx_byte == ngfe_pkg::CHAR_LF) begin
               push_a.valid         = 1'b1;
               push_a.item.kind     = ngfe_pkg::KIND_LINE_END;
               push_a.item.is_match = cur_match;
               line_reset           = 1'b1;
            end
         end else if (rx_byte == ngfe_pkg::CHAR_CR) begin
            cr_pending_in = 1'b1;
         end else begin
            if (rx_byte == ngfe_pkg::CHAR_COMMA) begin
               if (field_number_ff == 4'd0 && pos_in_field_ff != ID_LEN) begin
                  id_match_in = 1'b0;
               end
               if (field_number_ff != ngfe_pkg::CNT4_MAX) begin
                  field_number_in = field_number_ff + 4'd1;
               end
               pos_in_field_in = 4'd0;
            end else begin
               if (field_number_ff == 4'd0) begin
                  if (pos_in_field_ff >= ID_LEN ||
                      rx_byte != id_char[pos_in_field_ff[2:0]]) begin
                     id_match_in = 1'b0;
                  end
               end else if (id_match_ff && fid != ngfe_pkg::FIELD_NONE &&
                            pos_in_field_ff < ngfe_pkg::cap_of(fid)) begin
                  push_a.valid           = 1'b1;
                  push_a.item.kind       = ngfe_pkg::KIND_CHAR;
                  push_a.item.field_id   = fid;
                  push_a.item.char_index = pos_in_field_ff;
                  push_a.item.char_value = rx_byte;
               end
               if (pos_in_field_ff != ngfe_pkg::CNT4_MAX) begin
                  pos_in_field_in = pos_in_field_ff + 4'd1;
               end
            end
            stored_count_in = stored_count_ff + 10'd1;
            // match as it stands after this byte, before the line restarts
            next_match = (field_number_in == 4'd0) ?
                         (id_match_in && pos_in_field_in == ID_LEN) : id_match_in;
            // line cut: report after any character result of this byte
            if (stored_count_in >= limit) begin
               if (push_a.valid) begin
                  push_b.valid         = 1'b1;
                  push_b.item.kind     = ngfe_pkg::KIND_TRUNCATED;
                  push_b.item.is_match = next_match;
               end else begin
                  push_a.valid         = 1'b1;
                  push_a.item.kind     = ngfe_pkg::KIND_TRUNCATED;
                  push_a.item.is_match = next_match;
               end
               line_reset = 1'b1;
            end
         end
      end

      if (line_reset) begin
         stored_count_in = 10'd0;
         field_number_in = 4'd0;
         pos_in_field_in = 4'd0;
         id_match_in     = 1'b1;
         cr_pending_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff <= 10'd0;
         field_number_ff <= 4'd0;
         pos_in_field_ff <= 4'd0;
         id_match_ff     <= 1'b1;
         cr_pending_ff   <= 1'b0;
      end else begin
         stored_count_ff <= stored_count_in;
         field_number_ff <= field_number_in;
         pos_in_field_ff <= pos_in_field_in;
         id_match_ff     <= id_match_in;
         cr_pending_ff   <= cr_pending_in;
      end
   end

   `ASSERT_IMPLY(a_second_needs_first, clock, reset, push_b.valid, push_a.valid)
   `ASSERT_NEXT(a_line_end_restarts, clock, reset, lf_end, stored_count_ff == '0 && !cr_pending_ff)
   `ASSERT_IMPLY(a_no_result_when_idle, clock, reset, !fire, !push_a.valid)

endmodule

FILE: rtl/ngfe_rsp_queue.sv
// ----------------------------------------------------------------------------
// ngfe_rsp_queue
// small result queue taking up to two items per cycle, one out per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ngfe_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ngfe_pkg::push_type     push_a,
   input  ngfe_pkg::push_type     push_b,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ngfe_pkg::rsp_item_type out_item
);

   localparam int PTR_W = $clog2(ngfe_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(ngfe_pkg::RSP_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ngfe_pkg::RSP_DEPTH);

   ngfe_pkg::rsp_item_type slot_ff [ngfe_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] push_n;
   logic [PTR_W-1:0] tail_p1;
   logic             pop;

   assign room      = count_ff <= (DEPTH_C - CNT_W'(2));
   assign out_valid = count_ff != '0;
   assign out_item  = slot_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign push_n    = CNT_W'(push_a.valid) + CNT_W'(push_b.valid);
   assign tail_p1   = tail_ff + PTR_W'(1);

   assign head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
   assign tail_in  = tail_ff + PTR_W'(push_n);
   assign count_in = count_ff + push_n - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a.valid) begin
         slot_ff[tail_ff] <= push_a.item;
      end
      if (push_b.valid) begin
         slot_ff[tail_p1] <= push_b.item;
      end
   end

   `ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= DEPTH_C)
   `ASSERT_ALWAYS(a_no_overflow, clock, reset, ({1'b0, count_ff} + {1'b0, push_n}) <= {1'b0, DEPTH_C})

endmodule

FILE: rtl/nmea_gga_field_extractor_top.sv
// byte path: an accepted byte waits in the input register until the queue has
//   room, is then parsed, and its results are written into the result queue
// throughput: one byte per cycle while the result queue has room; a byte yields
//   at most two items, which leave one per cycle through a four-entry queue
// reset: synchronous, active high; line state cleared, max_line 1000, id "$GPGGA"
// ----------------------------------------------------------------------------
// nmea_gga_field_extractor_top
// frames received nmea bytes into lines and emits the gga position fields
// ----------------------------------------------------------------------------
module nmea_gga_field_extractor_top #(
   parameter int ID_CHARS = ngfe_pkg::ID_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_field_id,
   output logic [3:0]  rsp_char_index,
   output logic [7:0]  rsp_char_value,
   output logic        rsp_is_match,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   ngfe_pkg::cfg_type      cfg;
   ngfe_pkg::push_type     push_a;
   ngfe_pkg::push_type     push_b;
   ngfe_pkg::rsp_item_type head_item;

   // input register: one byte waiting for the parser
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       q_room;
   logic       parse_fire;
   logic       req_take;

   // the parser only runs when the queue can absorb a full two-item burst
   assign parse_fire = in_valid_ff && q_room;
   // input register frees up in the same cycle it is consumed
   assign req_ready  = !in_valid_ff || parse_fire;
   assign req_take   = req_valid && req_ready;

   assign in_valid_in = req_take ? 1'b1 : (parse_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   ngfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // framing, identifier check and field capture
   ngfe_parser #(
      .ID_CHARS (ID_CHARS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (parse_fire),
      .rx_byte (in_byte_ff),
      .push_a  (push_a),
      .push_b  (push_b)
   );

   // result queue, absorbs rsp stalls until it lacks room for two more items
   ngfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .push_b    (push_b),
      .room      (q_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head_item)
   );

   // unpack the head item onto the rsp ports
   assign rsp_result_kind = head_item.kind;
   assign rsp_field_id    = head_item.field_id;
   assign rsp_char_index  = head_item.char_index;
   assign rsp_char_value  = head_item.char_value;
   assign rsp_is_match    = head_item.is_match;

endmodule

FILE: tb/sv/tb_nmea_gga_field_extractor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmea_gga_field_extractor_top
// drives received bytes through the gga field extractor, tracks line framing,
// identifier matching and field capture alongside it, and compares every
// result item field by field under several register settings and idle mixes
// ----------------------------------------------------------------------------
module tb_nmea_gga_field_extractor_top;
   import ngfe_pkg::*;

   localparam int ID_LEN = ID_CHARS_DEFAULT;

   // output field ids
   localparam logic [2:0] FLD_TIME = 3'd0;
   localparam logic [2:0] FLD_LAT  = 3'd1;
   localparam logic [2:0] FLD_NS   = 3'd2;
   localparam logic [2:0] FLD_LON  = 3'd3;
   localparam logic [2:0] FLD_EW   = 3'd4;
   localparam logic [2:0] FLD_SATS = 3'd5;

   // register byte addresses, eight bytes apart since each register sits on the 64-bit data bus
   localparam logic [3:0] ADDR_MAX_LINE    = {REG_MAX_LINE, 3'b000};
   localparam logic [3:0] ADDR_SENTENCE_ID = {REG_SENTENCE_ID, 3'b000};

   // --------------------------------------------------------------------------
   // line tracker: follows the byte stream and queues the items it must cause
   // --------------------------------------------------------------------------
   class gga_line_tracker;
      logic [9:0]   max_line;
      logic [47:0]  sentence_id;
      logic [9:0]   line_len;
      logic [3:0]   field_no;
      logic [3:0]   char_pos;
      bit           id_ok;
      bit           saw_cr;
      rsp_item_type due_results[$];
      int unsigned  errors;

      function new();
         max_line    = MAX_LINE_RESET;
         sentence_id = SENTENCE_ID_RESET;
         errors      = 0;
         restart_line();
      endfunction

      function void restart_line();
         line_len = '0;
         field_no = '0;
         char_pos = '0;
         id_ok    = 1'b1;
         saw_cr   = 1'b0;
      endfunction

      function void push_line(result_kind_type kind);
         rsp_item_type it;
         it.kind       = kind;
         it.field_id   = '0;
         it.char_index = '0;
         it.char_value = '0;
         // still inside the identifier field: all of it must have arrived
         if (field_no == 0)
            it.is_match = id_ok && (char_pos == ID_LEN);
         else
            it.is_match = id_ok;
         due_results.push_back(it);
      endfunction

      function void take_byte(logic [7:0] b);
         logic [2:0]   fid;
         logic [3:0]   cap;
         int unsigned  limit;
         rsp_item_type it;
         // cr waits for its partner; anything but lf drops both
         if (saw_cr) begin
            saw_cr = 1'b0;
            if (b == CHAR_LF) begin
               push_line(KIND_LINE_END);
               restart_line();
            end
            return;
         end
         if (b == CHAR_CR) begin
            saw_cr = 1'b1;
            return;
         end
         if (b == CHAR_COMMA) begin
            if (field_no == 0 && char_pos != ID_LEN)
               id_ok = 1'b0;
            if (field_no != CNT4_MAX)
               field_no++;
            char_pos = '0;
         end else begin
            if (field_no == 0) begin
               if (char_pos >= ID_LEN ||
                   b != sentence_id[(ID_LEN - 1 - int'(char_pos)) * 8 +: 8])
                  id_ok = 1'b0;
            end else if (id_ok) begin
               case (field_no)
                  4'd1: begin
                     fid = FLD_TIME; cap = 4'd10;
                  end
                  4'd2: begin
                     fid = FLD_LAT;  cap = 4'd9;
                  end
                  4'd3: begin
                     fid = FLD_NS;   cap = 4'd1;
                  end
                  4'd4: begin
                     fid = FLD_LON;  cap = 4'd10;
                  end
                  4'd5: begin
                     fid = FLD_EW;   cap = 4'd1;
                  end
                  4'd7: begin
                     fid = FLD_SATS; cap = 4'd2;
                  end
                  default: begin
                     fid = FIELD_NONE; cap = 4'd0;
                  end
               endcase
               if (fid != FIELD_NONE && char_pos < cap) begin
                  it.kind       = KIND_CHAR;
                  it.field_id   = fid;
                  it.char_index = char_pos;
                  it.char_value = b;
                  it.is_match   = 1'b1;
                  due_results.push_back(it);
               end
            end
            if (char_pos != CNT4_MAX)
               char_pos++;
         end
         line_len = line_len + 10'd1;
         limit = (max_line >= 3) ? int'(max_line) - 2 : 1;
         if (int'(line_len) >= limit) begin
            push_line(KIND_TRUNCATED);
            restart_line();
         end
      endfunction

      function void match_result(logic [1:0] kind, logic [2:0] fid, logic [3:0] idx,
                                 logic [7:0] val, logic hit);
         rsp_item_type exp;
         if (due_results.size() == 0) begin
            $error("result item with none due: kind %0d field %0d index %0d value %0d",
                   kind, fid, idx, val);
            errors++;
            return;
         end
         exp = due_results.pop_front();
         if (kind !== exp.kind) begin
            $error("result_kind expected %0d actual %0d", exp.kind, kind);
            errors++;
         end
         if (fid !== exp.field_id) begin
            $error("field_id expected %0d actual %0d", exp.field_id, fid);
            errors++;
         end
         if (idx !== exp.char_index) begin
            $error("char_index expected %0d actual %0d", exp.char_index, idx);
            errors++;
         end
         if (val !== exp.char_value) begin
            $error("char_value expected %0d actual %0d", exp.char_value, val);
            errors++;
         end
         if (hit !== exp.is_match) begin
            $error("is_match expected %0d actual %0d", exp.is_match, hit);
            errors++;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and block ports
   // --------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_ready   = 1'b0;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [3:0]  paddr       = 4'd0;
   logic [63:0] pwdata      = 64'd0;

   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_field_id;
   logic [3:0]  rsp_char_index;
   logic [7:0]  rsp_char_value;
   logic        rsp_is_match;
   logic [63:0] prdata;
   logic        pready;

   // idle chances in percent for each side
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned bytes_sent    = 0;

   gga_line_tracker tracker = new();

   always #2 clock = ~clock;

   nmea_gga_field_extractor_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_field_id    (rsp_field_id),
      .rsp_char_index  (rsp_char_index),
      .rsp_char_value  (rsp_char_value),
      .rsp_is_match    (rsp_is_match),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // receiver: stalls at random with the current idle chance
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // sample both handshakes with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.match_result(rsp_result_kind, rsp_field_id, rsp_char_index,
                                 rsp_char_value, rsp_is_match);
         if (req_valid && req_ready)
            tracker.take_byte(req_rx_byte);
      end
   end

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------

   // one byte on the input channel, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // apb write: setup phase, then access until pready, then back to idle
   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [3:0] addr, output logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // hold the input idle until every due item has come, then wait extra cycles
   // more for bytes still in flight that cause nothing
   task automatic drain(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // write both registers while idle, read them back, and track the new values
   task automatic set_registers(input logic [9:0] ml, input logic [47:0] id);
      logic [63:0] rd;
      drain(4);
      csr_write(ADDR_MAX_LINE, {54'd0, ml});
      csr_write(ADDR_SENTENCE_ID, {16'd0, id});
      tracker.max_line    = ml;
      tracker.sentence_id = id;
      csr_read(ADDR_MAX_LINE, rd);
      if (rd[9:0] !== ml) begin
         $error("max_line expected %0d actual %0d", ml, rd[9:0]);
         tracker.errors++;
      end
      csr_read(ADDR_SENTENCE_ID, rd);
      if (rd[47:0] !== id) begin
         $error("sentence_id expected %h actual %h", id, rd[47:0]);
         tracker.errors++;
      end
   endtask

   // any byte but cr and comma, so the field carries on
   function automatic logic [7:0] field_char();
      logic [7:0] ch;
      if ($urandom_range(9) == 0) begin
         do ch = 8'($urandom_range(255)); while (ch == CHAR_CR || ch == CHAR_COMMA);
      end else begin
         ch = 8'($urandom_range(46, 90));
      end
      return ch;
   endfunction

   // well-formed sentence shape with random content; id mostly right
   task automatic send_sentence();
      int         pick;
      int         bad;
      int         nfields;
      int         flen;
      logic [7:0] ch;
      pick = $urandom_range(9);
      bad  = $urandom_range(ID_LEN - 1);
      if (pick <= 7) begin
         for (int k = 0; k < ID_LEN; k++) begin
            ch = tracker.sentence_id[(ID_LEN - 1 - k) * 8 +: 8];
            // one character off now and then
            if (pick == 7 && k == bad)
               ch = ch ^ (8'd1 << $urandom_range(7));
            send_byte(ch);
         end
      end else if (pick == 8) begin
         // identifier of random length and content
         flen = $urandom_range(8);
         for (int k = 0; k < flen; k++)
            send_byte(8'($urandom_range(36, 90)));
      end else begin
         // right identifier with a character too many
         for (int k = 0; k < ID_LEN; k++)
            send_byte(tracker.sentence_id[(ID_LEN - 1 - k) * 8 +: 8]);
         send_byte(field_char());
      end
      nfields = $urandom_range(10);
      for (int f = 0; f < nfields; f++) begin
         send_byte(CHAR_COMMA);
         flen = $urandom_range(12);
         for (int i = 0; i < flen; i++)
            send_byte(field_char());
      end
      pick = $urandom_range(19);
      if (pick < 16) begin
         send_byte(CHAR_CR);
         send_byte(CHAR_LF);
      end else if (pick == 16) begin
         // line end with a random byte after cr
         send_byte(CHAR_CR);
         send_byte(8'($urandom_range(255)));
      end else if (pick == 17) begin
         send_byte(CHAR_CR);
         send_byte(CHAR_CR);
         send_byte(CHAR_LF);
      end
      // otherwise the line just runs on into the next one
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(255)));
   endtask

   function automatic logic [47:0] random_id();
      logic [47:0] id;
      for (int k = 0; k < ID_LEN; k++)
         id[k * 8 +: 8] = 8'($urandom_range(33, 126));
      return id;
   endfunction

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      logic [9:0]  phase_max_line [6];
      logic [47:0] phase_id [6];
      int          phase_bytes [6];
      int          target;
      bit          held;

      // max_line extremes, a value below the floor, and a few ordinary settings
      phase_max_line = '{MAX_LINE_RESET, 10'd3, 10'd1023, 10'd20, 10'd0,
                         10'($urandom_range(40, 200))};
      phase_id       = '{SENTENCE_ID_RESET, 48'd0, {48{1'b1}}, 48'h2447_4E47_4741,
                         random_id(), SENTENCE_ID_RESET};
      phase_bytes    = '{130, 100, 150, 200, 70, 300};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 6; p++) begin
         // receiver idles heavily first, then the sender does, then neither
         case (p / 2)
            0: begin
               send_idle_pct = 14;
               rsp_idle_pct  = 73;
            end
            1: begin
               send_idle_pct = 73;
               rsp_idle_pct  = 14;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase

         if (p == 0) begin
            // matching line with an empty latitude
            send_text("$GPGGA,1,,N");
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
            // leading comma, then cr cr drops both and lf is kept as data
            send_byte(CHAR_COMMA);
            send_byte("Z");
            send_byte(CHAR_CR);
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
            // nul and all-ones as plain characters
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
         end else begin
            set_registers(phase_max_line[p], phase_id[p]);
         end

         bytes_sent = 0;
         target     = phase_bytes[p];
         held       = 1'b0;
         while (bytes_sent < target) begin
            // hold the sender once until the result side has caught up
            if (p == 3 && !held && bytes_sent >= target / 2) begin
               drain(0);
               held = 1'b1;
            end
            if ($urandom_range(9) == 0)
               send_noise();
            else
               send_sentence();
         end
      end

      // everything due has to arrive, then nothing more may come
      drain(10);
      if (tracker.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #800000;
      $display("Verification failed");
      $finish;
   end

endmodule
